### hdl/assert_macros.svh
// assertion macros used by the checker of the efficiency counter table
// no dependencies; every macro clocks on the rising edge and is off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every active edge
`define ECT_ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) \
    else $error("%m: assertion failed");

// consequent holds at the same edge as the antecedent
`define ECT_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// consequent holds at the edge after the antecedent
`define ECT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### hdl/ect_pkg.sv
// shared constants, types and address helpers of the efficiency counter table
// no dependencies; used by every module of the block
`default_nettype none

package ect_pkg;

  localparam int NumChambers = 72;
  localparam int NumColumns  = 7;
  localparam int NumLines    = 4;
  localparam int CountWidth  = 32;
  localparam int FracBits    = 16;

  localparam int NumCells   = NumChambers * NumColumns * NumLines;
  localparam int NumEntries = NumCells * 4;
  localparam int CellW      = $clog2(NumCells);
  localparam int AddrW      = CellW + 2;
  localparam int IdxW       = CellW + 4;
  localparam int AluW       = CountWidth + 1;
  localparam int EffW       = FracBits + 1;
  localparam int IterW      = $clog2(FracBits + 1);

  // counter slot inside a cell, also the plane selector code
  localparam logic [1:0] CntBend    = 2'd0;
  localparam logic [1:0] CntNonbend = 2'd1;
  localparam logic [1:0] CntBoth    = 2'd2;
  localparam logic [1:0] CntTotal   = 2'd3;

  // record operation codes
  localparam logic OpRecord = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_REC_RD,
    S_REC_WR,
    S_Q_RDT,
    S_Q_RDP,
    S_Q_LAT,
    S_DIV,
    S_FIN
  } state_t;

  // shared adder request: increment a, or a minus b with carry as a >= b
  typedef struct packed {
    logic            inc;
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] sum;
    logic            carry;
  } alu_rsp_t;

  typedef struct packed {
    logic                  we;
    logic [AddrW-1:0]      addr;
    logic [CountWidth-1:0] wdata;
  } ram_req_t;

  function automatic logic [CellW-1:0] cell_index(input logic [6:0] chamber,
                                                  input logic [2:0] column,
                                                  input logic [1:0] board_line);
    logic [IdxW-1:0] acc;
    acc = IdxW'(chamber) * IdxW'(NumColumns * NumLines)
        + IdxW'(column) * IdxW'(NumLines)
        + IdxW'(board_line);
    return acc[CellW-1:0];
  endfunction

  // record sequence: total first, then the hit counters
  function automatic logic [1:0] step_slot(input logic [1:0] step);
    logic [1:0] slot;
    case (step)
      2'd0:    slot = CntTotal;
      2'd1:    slot = CntBend;
      2'd2:    slot = CntNonbend;
      default: slot = CntBoth;
    endcase
    return slot;
  endfunction

endpackage

`default_nettype wire

### hdl/ect_alu.sv
// shared adder of the efficiency counter table: saturating increment and divide step
// depends on ect_pkg for the request and response types
`default_nettype none

module ect_alu (
  input  ect_pkg::alu_req_t req,
  output ect_pkg::alu_rsp_t rsp
);

  logic [ect_pkg::AluW:0] addend;
  logic [ect_pkg::AluW:0] cin;
  logic [ect_pkg::AluW:0] sum;

  // one adder: a + 1, or a + ~b + 1
  always_comb begin
    if (req.inc) begin
      addend = {{ect_pkg::AluW{1'b0}}, 1'b1};
      cin    = '0;
    end else begin
      addend = {1'b0, ~req.b};
      cin    = {{ect_pkg::AluW{1'b0}}, 1'b1};
    end
    sum       = {1'b0, req.a} + addend + cin;
    rsp.sum   = sum[ect_pkg::AluW-1:0];
    rsp.carry = sum[ect_pkg::AluW];
  end

endmodule

`default_nettype wire

### hdl/ect_ram.sv
// single-port counter memory of the efficiency counter table, registered read
// depends on ect_pkg for depth, width and the request type
`default_nettype none

module ect_ram (
  input  wire                                  clk,
  input  ect_pkg::ram_req_t                    req,
  output logic [ect_pkg::CountWidth-1:0]       rd_data
);

  logic [ect_pkg::CountWidth-1:0] mem [ect_pkg::NumEntries];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end

endmodule

`default_nettype wire

### hdl/efficiency_counter_table.sv
// top level of the efficiency counter table: sequencer, working registers, result register
// depends on ect_pkg, ect_alu and ect_ram
//
// Per-cell event counters (bending, non-bending, both-plane, total) for 2016 detector
// cells addressed by chamber, column and board line, kept in one single-port memory of
// 8064 counters. After reset the block runs a clearing pass, one counter per cycle,
// with in_tready low. One request is processed at a time: in_tready is high only while
// the sequencer idles, but a finished result sits in the output register so the next
// request can be taken while it waits. A record does a read and a write-back per
// counter it touches (total always, then each enabled hit counter; disabled ones are
// skipped), all increments done on the shared saturating adder. A query does two memory
// reads (total, then the selected counter), then 17 restoring-division steps, one
// quotient bit per cycle, on the same 33-bit adder; a query on a cell never recorded
// skips the division. A request with an address out of range goes straight to the
// final state. If the output register still holds an unaccepted result when the next
// one is finished, the sequencer waits in its final state until it leaves.
// The seen mark of a cell is the nonzero test of its total counter: the total always
// counts up on a record and saturates, so it is nonzero exactly when the cell was seen.
`default_nettype none

module efficiency_counter_table (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // chamber[6:0], column[9:7], board_line[11:10], bend_hit[12], nonbend_hit[13],
  // plane_select[15:14]
  input  wire  [15:0] in_tdata,
  // operation[0]
  input  wire  [0:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // efficiency[16:0], passed_count[48:17], total_count[80:49], zero fill [87:81]
  output logic [87:0] out_tdata,
  // found[0]
  output logic [0:0]  out_tuser
);

  // fields of the incoming request
  logic [6:0] in_chamber;
  logic [2:0] in_column;
  logic [1:0] in_board_line;
  logic       in_bend_hit;
  logic       in_nonbend_hit;
  logic [1:0] in_plane_select;
  logic       in_addr_ok;
  logic       in_req;

  always_comb begin
    in_chamber      = in_tdata[6:0];
    in_column       = in_tdata[9:7];
    in_board_line   = in_tdata[11:10];
    in_bend_hit     = in_tdata[12];
    in_nonbend_hit  = in_tdata[13];
    in_plane_select = in_tdata[15:14];
    in_addr_ok      = ({1'b0, in_chamber} < 8'(ect_pkg::NumChambers))
                   && ({1'b0, in_column} < 4'(ect_pkg::NumColumns))
                   && ({2'b00, in_board_line} < 4'(ect_pkg::NumLines));
    in_req          = in_tvalid && in_tready;
  end

  // sequencer and working registers
  ect_pkg::state_t                 state_r, state_nxt;
  logic [1:0]                      step_r, step_nxt;
  logic [ect_pkg::IterW-1:0]       iter_r, iter_nxt;
  logic [ect_pkg::AddrW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [ect_pkg::CellW-1:0]       cell_r, cell_nxt;
  logic                            bend_r, bend_nxt;
  logic                            nonbend_r, nonbend_nxt;
  logic [1:0]                      sel_r, sel_nxt;
  logic [ect_pkg::CountWidth-1:0]  den_r, den_nxt;
  logic [ect_pkg::CountWidth-1:0]  passed_r, passed_nxt;
  logic [ect_pkg::CountWidth-1:0]  rem_r, rem_nxt;
  logic [ect_pkg::EffW-1:0]        quo_r, quo_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [ect_pkg::EffW-1:0]        out_eff_r, out_eff_nxt;
  logic [ect_pkg::CountWidth-1:0]  out_passed_r, out_passed_nxt;
  logic [ect_pkg::CountWidth-1:0]  out_total_r, out_total_nxt;

  ect_pkg::alu_req_t               alu_req;
  ect_pkg::alu_rsp_t               alu_rsp;
  ect_pkg::ram_req_t               ram_req;
  logic [ect_pkg::CountWidth-1:0]  ram_rd_data;

  logic                            step_en;
  logic                            step_last;
  logic [1:0]                      slot;

  ect_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ect_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    iter_nxt       = iter_r;
    clr_cnt_nxt    = clr_cnt_r;
    cell_nxt       = cell_r;
    bend_nxt       = bend_r;
    nonbend_nxt    = nonbend_r;
    sel_nxt        = sel_r;
    den_nxt        = den_r;
    passed_nxt     = passed_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_eff_nxt    = out_eff_r;
    out_passed_nxt = out_passed_r;
    out_total_nxt  = out_total_r;

    slot      = ect_pkg::step_slot(step_r);
    step_last = (step_r == 2'd3);
    case (step_r)
      2'd0:    step_en = 1'b1;
      2'd1:    step_en = bend_r;
      2'd2:    step_en = nonbend_r;
      default: step_en = bend_r && nonbend_r;
    endcase

    // default: saturating increment of the word just read
    alu_req.inc = 1'b1;
    alu_req.a   = {1'b0, ram_rd_data};
    alu_req.b   = {1'b0, den_r};

    ram_req.we    = 1'b0;
    ram_req.addr  = {cell_r, slot};
    ram_req.wdata = ram_rd_data;

    in_tready = (state_r == ect_pkg::S_IDLE);

    case (state_r)
      ect_pkg::S_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_cnt_r;
        ram_req.wdata = '0;
        if (clr_cnt_r == ect_pkg::AddrW'(ect_pkg::NumEntries - 1)) begin
          state_nxt = ect_pkg::S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      ect_pkg::S_IDLE: begin
        if (in_req) begin
          cell_nxt    = ect_pkg::cell_index(in_chamber, in_column, in_board_line);
          bend_nxt    = in_bend_hit;
          nonbend_nxt = in_nonbend_hit;
          sel_nxt     = in_plane_select;
          step_nxt    = 2'd0;
          // zero result unless a valid query fills it
          den_nxt     = '0;
          passed_nxt  = '0;
          quo_nxt     = '0;
          if (!in_addr_ok) begin
            state_nxt = ect_pkg::S_FIN;
          end else if (in_tuser[0] == ect_pkg::OpRecord) begin
            state_nxt = ect_pkg::S_REC_RD;
          end else begin
            state_nxt = ect_pkg::S_Q_RDT;
          end
        end
      end

      ect_pkg::S_REC_RD: begin
        // the read of the slot is issued here; skipped slots move on at once
        if (step_en) begin
          state_nxt = ect_pkg::S_REC_WR;
        end else if (step_last) begin
          state_nxt = ect_pkg::S_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      ect_pkg::S_REC_WR: begin
        ram_req.we = 1'b1;
        // sum bit at the count width is set only when the counter was at its maximum
        if (alu_rsp.sum[ect_pkg::CountWidth]) begin
          ram_req.wdata = ram_rd_data;
        end else begin
          ram_req.wdata = alu_rsp.sum[ect_pkg::CountWidth-1:0];
        end
        if (step_last) begin
          state_nxt = ect_pkg::S_FIN;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ect_pkg::S_REC_RD;
        end
      end

      ect_pkg::S_Q_RDT: begin
        ram_req.addr = {cell_r, ect_pkg::CntTotal};
        state_nxt    = ect_pkg::S_Q_RDP;
      end

      ect_pkg::S_Q_RDP: begin
        ram_req.addr = {cell_r, sel_r};
        den_nxt      = ram_rd_data;
        state_nxt    = ect_pkg::S_Q_LAT;
      end

      ect_pkg::S_Q_LAT: begin
        passed_nxt = ram_rd_data;
        rem_nxt    = ram_rd_data;
        iter_nxt   = '0;
        // a cell never recorded has a zero total: efficiency stays zero
        if (den_r == '0) begin
          state_nxt = ect_pkg::S_FIN;
        end else begin
          state_nxt = ect_pkg::S_DIV;
        end
      end

      ect_pkg::S_DIV: begin
        alu_req.inc = 1'b0;
        // integer bit first without shift, then one fraction bit per step
        if (iter_r == '0) begin
          alu_req.a = {1'b0, rem_r};
        end else begin
          alu_req.a = {rem_r, 1'b0};
        end
        quo_nxt = {quo_r[ect_pkg::EffW-2:0], alu_rsp.carry};
        if (alu_rsp.carry) begin
          rem_nxt = alu_rsp.sum[ect_pkg::CountWidth-1:0];
        end else begin
          rem_nxt = alu_req.a[ect_pkg::CountWidth-1:0];
        end
        if (iter_r == ect_pkg::IterW'(ect_pkg::FracBits)) begin
          state_nxt = ect_pkg::S_FIN;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end

      ect_pkg::S_FIN: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = (den_r != '0);
          out_eff_nxt    = quo_r;
          out_passed_nxt = passed_r;
          out_total_nxt  = den_r;
          state_nxt      = ect_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ect_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ect_pkg::S_CLR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      step_r      <= step_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    cell_r       <= cell_nxt;
    bend_r       <= bend_nxt;
    nonbend_r    <= nonbend_nxt;
    sel_r        <= sel_nxt;
    den_r        <= den_nxt;
    passed_r     <= passed_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    out_found_r  <= out_found_nxt;
    out_eff_r    <= out_eff_nxt;
    out_passed_r <= out_passed_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {7'b0, out_total_r, out_passed_r, out_eff_r};

endmodule

`default_nettype wire

### hdl/ect_checker.sv
// port-level checker of the efficiency counter table, bound to the top level
// depends on assert_macros.svh and the top level's port list
`default_nettype none
`include "assert_macros.svh"

module ect_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [87:0] out_tdata,
  input wire [0:0]  out_tuser
);

  // a stalled result holds
  `ECT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one request at a time: busy right after a request is taken
  `ECT_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // results without a seen cell carry no efficiency
  `ECT_ASSERT_IMPLIES(a_unfound_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[16:0] == 17'd0)

  // a seen cell has a nonzero total
  `ECT_ASSERT_IMPLIES(a_found_total, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[80:49] != 32'd0)

  // efficiency never exceeds one
  `ECT_ASSERT_IMPLIES(a_eff_range, clk, rst_n, out_tvalid, !out_tdata[16] || (out_tdata[15:0] == 16'd0))

endmodule

bind efficiency_counter_table ect_checker u_ect_checker (.*);

`default_nettype wire
